[design/mvm_pkg.sv]
// Shared types and constants for the matrix-vector multiply block.
`timescale 1ns / 1ps
package mvm_pkg;

  localparam int COL_W = 10;
  localparam int VAL_W = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W = 48;
  localparam int SIZE_W = 11;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // Request codes on cmd_i.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MATRIX = 1'b1;

  // Register index taken from paddr[2].
  localparam logic REG_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_ACC  = 3'b100
  } mvm_state_e;

  typedef struct packed {
    logic load_we;
    logic capture;
    logic mul_en;
    logic acc_en;
  } mvm_cmd_t;

  typedef struct packed {
    logic in_store;
    logic in_range;
    logic is_last;
  } mvm_status_t;

endpackage

[design/mvm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/mvm_ctrl.sv]
// Controller state machine that sequences vector loads and matrix MACs.
`timescale 1ns / 1ps
module mvm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                cmd_i,
  input  mvm_pkg::mvm_status_t status_i,
  output logic                busy,
  output mvm_pkg::mvm_cmd_t   ctrl_o
);
  import mvm_pkg::*;

  mvm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    busy = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (cmd_i == CMD_LOAD) begin
            ctrl_o.load_we = status_i.in_store;
          end else if (status_i.in_range) begin
            // The vector entry is read at this edge and is ready in ST_MUL.
            ctrl_o.capture = 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        ctrl_o.mul_en = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        ctrl_o.acc_en = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/mvm_datapath.sv]
// Datapath: vector store, multiplier, row accumulator, row counter, result registers.
`timescale 1ns / 1ps
module mvm_datapath #(
  parameter int MAX_SIZE = 1024,
  parameter int NW = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mvm_pkg::mvm_cmd_t              ctrl_i,
  output mvm_pkg::mvm_status_t           status_o,
  input  logic [NW-1:0]                  size_n_i,
  input  logic [mvm_pkg::COL_W-1:0]      col_i,
  input  logic [mvm_pkg::VAL_W-1:0]      value_i,
  output logic [mvm_pkg::COL_W-1:0]      row_o,
  output logic [mvm_pkg::SUM_W-1:0]      sum_o,
  output logic                           last_o,
  output logic                           done_o
);
  import mvm_pkg::*;

  localparam int AW = $clog2(MAX_SIZE);
  localparam int CMP_W = (NW > COL_W) ? NW : COL_W;

  logic [AW-1:0]            addr;
  logic [VAL_W-1:0]         vec_data;
  logic signed [VAL_W-1:0]  value_q;
  logic                     is_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]         acc_q, acc_d;
  logic [COL_W-1:0]         row_q;
  logic [SUM_W-1:0]         acc_sum;
  logic [NW-1:0]            last_index;
  logic                     final_row;
  logic [COL_W-1:0]         row_out_q;
  logic [SUM_W-1:0]         sum_out_q;
  logic                     last_out_q;
  logic                     done_q;

  assign addr = AW'(col_i);
  assign last_index = size_n_i - NW'(1);

  assign status_o.in_store = CMP_W'(col_i) < CMP_W'(MAX_SIZE);
  assign status_o.in_range = CMP_W'(col_i) < CMP_W'(size_n_i);
  assign status_o.is_last  = CMP_W'(col_i) == CMP_W'(last_index);

  mvm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_SIZE)
  ) u_vec_ram (
    .clk_i    (clk_i),
    .we_i     (ctrl_i.load_we),
    .wr_addr_i(addr),
    .wr_data_i(value_i),
    .rd_en_i  (ctrl_i.capture),
    .rd_addr_i(addr),
    .rd_data_o(vec_data)
  );

  // A row counter left past the end by a shrunk size still counts as final.
  assign final_row = CMP_W'(row_q) >= CMP_W'(last_index);
  assign acc_sum = acc_q + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d = is_last_q ? '0 : acc_sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      value_q <= value_i;
      is_last_q <= status_o.is_last;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= value_q * $signed(vec_data);
    end
    if (ctrl_i.acc_en && is_last_q) begin
      row_out_q <= row_q;
      sum_out_q <= acc_sum;
      last_out_q <= final_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      row_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.acc_en && is_last_q;
      if (ctrl_i.acc_en) begin
        acc_q <= acc_d;
        if (is_last_q) begin
          row_q <= final_row ? '0 : row_q + COL_W'(1);
        end
      end
    end
  end

  assign row_o = row_out_q;
  assign sum_o = sum_out_q;
  assign last_o = last_out_q;
  assign done_o = done_q;

endmodule

[design/matrix_vector_multiply.sv]
// Top level of the fixed-point matrix-vector multiply block.
// Usage: set size_in_use (n) over the APB port, load the vector with
// cmd_i = 0 requests (col_i = index, value_i = Q8.8 element), then stream
// the matrix row-major with cmd_i = 1 requests tagged by column. A request
// is taken at a clock edge where start is high and busy is low.
// A vector load produces no result. A matrix element runs through the vector
// store read, multiply and accumulate steps; busy is high for the multiply
// and accumulate steps. The element in column n-1 closes its row: in the
// cycle right after the accumulate cycle, done_o pulses for one cycle with
// row_o, the exact Q32.16 sum_o and last_o set for the final row.
// Throughput: one vector load per cycle; a new matrix element is taken only
// after the read, multiply and accumulate steps of the last one are done.
// Elements whose column is at or beyond n are dropped without a result.
// Reset clears the accumulator, the row counter and the size to 1024; the
// vector store keeps no reset and must be loaded before use.
// Results cannot be stalled: the receiver must take each done_o pulse.
`timescale 1ns / 1ps
module matrix_vector_multiply #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mvm_pkg::APB_AW-1:0]      paddr,
  input  logic [mvm_pkg::APB_DW-1:0]      pwdata,
  output logic [mvm_pkg::APB_DW-1:0]      prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd_i,
  input  logic [mvm_pkg::COL_W-1:0]       col_i,
  input  logic [mvm_pkg::VAL_W-1:0]       value_i,
  output logic                            done_o,
  output logic [mvm_pkg::COL_W-1:0]       row_o,
  output logic [mvm_pkg::SUM_W-1:0]       sum_o,
  output logic                            last_o
);
  import mvm_pkg::*;

  localparam int NW = $clog2(MAX_SIZE + 1);
  localparam int EW = (NW > SIZE_W) ? NW : SIZE_W;

  logic [SIZE_W-1:0] size_q;
  logic [NW-1:0]     size_n;
  logic              reg_sel;
  mvm_cmd_t          ctrl;
  mvm_status_t       status;

  assign reg_sel = paddr[APB_AW-1] == REG_SIZE;
  assign pready = 1'b1;
  assign prdata = reg_sel ? APB_DW'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  // Zero acts as one and anything above the store depth as the depth.
  always_comb begin
    if (size_q == '0) begin
      size_n = NW'(1);
    end else if (EW'(size_q) > EW'(MAX_SIZE)) begin
      size_n = NW'(MAX_SIZE);
    end else begin
      size_n = NW'(size_q);
    end
  end

  mvm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .cmd_i   (cmd_i),
    .status_i(status),
    .busy    (busy),
    .ctrl_o  (ctrl)
  );

  mvm_datapath #(
    .MAX_SIZE(MAX_SIZE),
    .NW      (NW)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .status_o(status),
    .size_n_i(size_n),
    .col_i   (col_i),
    .value_i (value_i),
    .row_o   (row_o),
    .sum_o   (sum_o),
    .last_o  (last_o),
    .done_o  (done_o)
  );

endmodule

[design/mvm_checker.sv]
// Port-level checker for the matrix-vector multiply block, bound to the top level.
`timescale 1ns / 1ps
module mvm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic pready
);

  // Each result comes from a matrix element, which runs through the read, multiply and accumulate steps.
  a_no_adjacent_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o pulsed in two adjacent cycles");

  // A result is emitted after the accumulate cycle, during which busy was high.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("done_o without a preceding accumulate cycle");

  // A matrix element keeps the block busy only in the multiply and accumulate states.
  a_busy_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |=> !busy)
    else $error("busy held longer than two cycles");

  // Busy only rises after a request was taken.
  a_busy_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .pready(pready)
);
